// ===== hdl/pal_pkg.sv =====
`timescale 1ns / 1ps
// pal_pkg: sizes, request codes and the per-cycle command bundle for the
// positional array list. No dependencies.
package pal_pkg;

  // list geometry
  localparam int DEPTH  = 128;
  localparam int WIDTH  = 32;

  // fixed port field widths
  localparam int TYPE_W = 2;
  localparam int POS_W  = 7;
  localparam int ITEM_W = 32;
  localparam int ECNT_W = 8;

  // count holds 0..DEPTH; compares run at the wider of count and position
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [TYPE_W-1:0] {
    REQ_INSERT   = 2'd0,
    REQ_REMOVE   = 2'd1,
    REQ_RETRIEVE = 2'd2,
    REQ_REPLACE  = 2'd3
  } req_t;

  // command broadcast to every cell; the flags are already qualified
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic             rep;
    logic [CMP_W-1:0] pos;
    logic [WIDTH-1:0] data;
  } cmd_t;

endpackage

// ===== hdl/pal_cell.sv =====
`timescale 1ns / 1ps
// pal_cell: one list slot. Holds one entry, shifts with its neighbors on
// insert and remove, loads on a hit. Depends on pal_pkg.
module pal_cell
  import pal_pkg::*;
(
  input  logic             clk,
  input  logic [CMP_W-1:0] idx,
  input  cmd_t             cmd,
  input  logic [WIDTH-1:0] left_in,
  input  logic [WIDTH-1:0] right_in,
  output logic [WIDTH-1:0] word,
  output logic [WIDTH-1:0] tap
);

  logic             hit;
  logic             above;
  logic [WIDTH-1:0] word_next;

  assign hit   = (idx == cmd.pos);
  assign above = (idx > cmd.pos);

  // slot update: insert pulls from below, remove pulls from above
  always_comb begin
    word_next = word;
    if (cmd.ins) begin
      if (above) begin
        word_next = left_in;
      end else if (hit) begin
        word_next = cmd.data;
      end
    end else if (cmd.rem) begin
      if (above || hit) begin
        word_next = right_in;
      end
    end else if (cmd.rep && hit) begin
      word_next = cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // read tap, OR-combined across the row
  assign tap = word & {WIDTH{hit}};

endmodule

// ===== hdl/positional_array_list.sv =====
`timescale 1ns / 1ps
// positional_array_list: ordered list of DEPTH words held in a row of
// pal_cell slots, with request decode and result register. Depends on pal_pkg.
//
//  channel   handshake                 fields
//  request   start & !busy             req_type, position, write_item
//  result    result_valid (no stall)   ok, read_item, entry_count
//
// One request per cycle; the result beat is registered and appears in the cycle after accept.
// All affected slots shift in the same cycle, so insert and remove never hold up requests.
// busy is never raised. Reset (rst, synchronous) empties the list; slot
// contents are not cleared since slots at or above the count are never read.
// The receiver cannot stall: each result beat is valid for one cycle only.
module positional_array_list
  import pal_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [TYPE_W-1:0]        req_type,
  input  logic [POS_W-1:0]         position,
  input  logic signed [ITEM_W-1:0] write_item,
  output logic                     result_valid,
  output logic                     ok,
  output logic signed [ITEM_W-1:0] read_item,
  output logic [ECNT_W-1:0]        entry_count
);

  logic                  accept;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [CMP_W-1:0]      pos_x;
  logic [CMP_W-1:0]      cnt_x;
  logic                  req_ok;
  logic                  is_get;
  cmd_t                  cmd;
  logic [WIDTH-1:0]      words [DEPTH];
  logic [WIDTH-1:0]      taps  [DEPTH];
  logic [WIDTH-1:0]      rd_word;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pos_x  = CMP_W'(position);
  assign cnt_x  = CMP_W'(count);

  // request decode and range check
  always_comb begin
    req_ok     = 1'b0;
    is_get     = 1'b0;
    count_next = count;
    cmd.ins    = 1'b0;
    cmd.rem    = 1'b0;
    cmd.rep    = 1'b0;
    cmd.pos    = pos_x;
    cmd.data   = WIDTH'($unsigned(write_item));
    if (accept) begin
      unique case (req_t'(req_type))
        REQ_INSERT: begin
          req_ok     = (count < CNT_W'(DEPTH)) && (pos_x <= cnt_x);
          cmd.ins    = req_ok;
          count_next = req_ok ? count + 1'b1 : count;
        end
        REQ_REMOVE: begin
          req_ok     = (pos_x < cnt_x);
          cmd.rem    = req_ok;
          count_next = req_ok ? count - 1'b1 : count;
        end
        REQ_RETRIEVE: begin
          req_ok = (pos_x < cnt_x);
          is_get = req_ok;
        end
        REQ_REPLACE: begin
          req_ok  = (pos_x < cnt_x);
          cmd.rep = req_ok;
        end
        default: req_ok = 1'b0;
      endcase
    end
  end

  // row of slots, each linked to both neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] left_w;
    logic [WIDTH-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[i+1];
    end
    pal_cell u_cell (
      .clk      (clk),
      .idx      (CMP_W'(i)),
      .cmd      (cmd),
      .left_in  (left_w),
      .right_in (right_w),
      .word     (words[i]),
      .tap      (taps[i])
    );
  end

  // read select: at most one tap is nonzero
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_word = rd_word | taps[k];
    end
  end

  // count and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      count        <= count_next;
      result_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    ok          <= req_ok;
    read_item   <= is_get ? ITEM_W'(rd_word) : '0;
    entry_count <= ECNT_W'(count_next);
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("list count above depth");

  a_beat_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("missing result beat after accept");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> (count == $past(count) + 1'b1))
    else $error("insert did not grow the count");

  a_fail_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && !req_ok) |=> $stable(count))
    else $error("failed request changed the count");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !ok) |-> (read_item == '0))
    else $error("nonzero read data on failed request");

endmodule
